// ----- design/crc_codeword_sender_defines.svh -----
// Assertion macros for the CRC codeword sender checker.
// Needs clk and arst_n in the scope of each use.
`ifndef CRC_CODEWORD_SENDER_DEFINES_SVH
`define CRC_CODEWORD_SENDER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CCS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("crc_codeword_sender: assertion failed");

// next-cycle implication, disabled during reset
`define CCS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("crc_codeword_sender: assertion failed");

`endif

// ----- design/ccs_pkg.sv -----
// Shared types and constants for the CRC codeword sender.
// No dependencies.
`timescale 1ns / 1ps
package ccs_pkg;

	localparam int MAX_DEGREE = 32;
	localparam int REM_W      = MAX_DEGREE;
	localparam int REM_IDX_W  = $clog2(REM_W);
	localparam int DEG_W      = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_POLY   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_DEGREE = CFG_IDX_W'(1);

	// one classified word handed from front to back
	typedef struct packed {
		logic             bit_val;
		logic             eom;
		logic [REM_W-1:0] rem;   // remainder after this bit, already masked to deg
		logic [DEG_W-1:0] deg;   // effective degree, 1..MAX_DEGREE
	} ccs_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} ccs_fifo_stat_t;

endpackage

// ----- design/crc_codeword_sender.sv -----
// Systematic CRC encoder, programmable generator x^d + poly_low_terms, zero init, no
// final XOR. Message bits go in one per cycle while in_stall is low (highest order first)
// and each comes out unchanged as a codeword word via the queue and output register;
// after the word flagged end_of_message the d remainder bits follow, MSB first, one per
// cycle unless out_stall holds the output, the last one flagged last_code_bit. Data words
// can follow back to back with no gap. An n-bit message gives n + d codeword bits. A
// 4-word queue separates the remainder update from the output serializer: while check
// bits go out the input takes up to four more words, then in_stall rises until a word
// leaves the queue. A stalled output also fills the queue. crc_degree of 0 acts as 1,
// above 32 acts as 32. Write configuration only while the block is idle.
// Depends on ccs_pkg, ccs_front, ccs_fifo, ccs_back.
`timescale 1ns / 1ps
module crc_codeword_sender import ccs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  message_bit,
	input  logic                  end_of_message,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  code_bit,
	output logic                  is_check_bit,
	output logic                  last_code_bit,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [REM_W-1:0] poly_q;
	logic [DEG_W-1:0] degree_q;
	ccs_fifo_stat_t   fifo_stat;
	ccs_entry_t       push_entry;
	ccs_entry_t       pop_entry;
	logic             push;
	logic             pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q   <= REM_W'(3);
			degree_q <= DEG_W'(3);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_POLY:   poly_q   <= cfg_data[REM_W-1:0];
				REG_DEGREE: degree_q <= cfg_data[DEG_W-1:0];
				default:    poly_q   <= poly_q;
			endcase
		end
	end

	ccs_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.message_bit    (message_bit),
		.end_of_message (end_of_message),
		.poly_q         (poly_q),
		.degree_q       (degree_q),
		.fifo_stat      (fifo_stat),
		.push           (push),
		.push_entry     (push_entry)
	);

	ccs_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.stat       (fifo_stat)
	);

	ccs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.fifo_stat     (fifo_stat),
		.pop_entry     (pop_entry),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.code_bit      (code_bit),
		.is_check_bit  (is_check_bit),
		.last_code_bit (last_code_bit)
	);

endmodule

// ----- design/ccs_front.sv -----
// Front end: accepts message bits and runs the bit-serial remainder update.
// Depends on ccs_pkg.
`timescale 1ns / 1ps
module ccs_front import ccs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  message_bit,
	input  logic                  end_of_message,
	input  logic [REM_W-1:0]      poly_q,
	input  logic [DEG_W-1:0]      degree_q,
	input  ccs_fifo_stat_t        fifo_stat,
	output logic                  push,
	output ccs_entry_t            push_entry
);

	logic [REM_W-1:0] rem_q;
	logic [DEG_W-1:0] deg_eff;
	logic [DEG_W-1:0] deg_dec;
	logic [REM_W-1:0] mask;
	logic [REM_W-1:0] rem_next;
	logic             fb;

	always_comb begin
		priority if (degree_q == '0) begin
			deg_eff = DEG_W'(1);
		end else if (degree_q > DEG_W'(MAX_DEGREE)) begin
			deg_eff = DEG_W'(MAX_DEGREE);
		end else begin
			deg_eff = degree_q;
		end
	end

	always_comb begin
		for (int i = 0; i < REM_W; i++) begin
			mask[i] = (DEG_W'(i) < deg_eff);
		end
	end

	assign deg_dec  = deg_eff - DEG_W'(1);
	assign fb       = rem_q[deg_dec[REM_IDX_W-1:0]] ^ message_bit;
	assign rem_next = ((rem_q << 1) & mask) ^ ({REM_W{fb}} & poly_q & mask);

	assign in_stall = fifo_stat.full;
	assign push     = in_valid && !fifo_stat.full;

	assign push_entry.bit_val = message_bit;
	assign push_entry.eom     = end_of_message;
	assign push_entry.rem     = rem_next;
	assign push_entry.deg     = deg_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (push) begin
			// end of message: the remainder travels in the word, register restarts
			rem_q <= end_of_message ? '0 : rem_next;
		end
	end

endmodule

// ----- design/ccs_fifo.sv -----
// Short word queue between front and back ends.
// Depends on ccs_pkg.
`timescale 1ns / 1ps
module ccs_fifo import ccs_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ccs_entry_t     push_entry,
	input  logic           pop,
	output ccs_entry_t     pop_entry,
	output ccs_fifo_stat_t stat
);

	ccs_entry_t              mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]   wr_ptr_q;
	logic [FIFO_PTR_W-1:0]   rd_ptr_q;
	logic [FIFO_CNT_W-1:0]   count_q;

	assign stat.full  = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign stat.empty = (count_q == '0);
	assign pop_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + FIFO_CNT_W'(1);
				2'b01:   count_q <= count_q - FIFO_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- design/ccs_back.sv -----
// Back end: emits the data bit of each word, then the check bits after a final word.
// Depends on ccs_pkg.
`timescale 1ns / 1ps
module ccs_back import ccs_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  ccs_fifo_stat_t fifo_stat,
	input  ccs_entry_t     pop_entry,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic           code_bit,
	output logic           is_check_bit,
	output logic           last_code_bit
);

	typedef enum logic [1:0] {
		ST_DATA  = 2'b01,
		ST_CHECK = 2'b10
	} state_t;

	state_t           state_q;
	logic [REM_W-1:0] shreg_q;
	logic [DEG_W-1:0] cnt_q;    // check bits still to send
	logic [DEG_W-1:0] cnt_dec;
	logic             out_valid_q;
	logic             code_bit_q;
	logic             is_check_q;
	logic             last_q;
	logic             out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign cnt_dec  = cnt_q - DEG_W'(1);
	assign pop      = (state_q == ST_DATA) && out_free && !fifo_stat.empty;

	assign out_valid     = out_valid_q;
	assign code_bit      = code_bit_q;
	assign is_check_bit  = is_check_q;
	assign last_code_bit = last_q;

	always_ff @(posedge clk) begin
		if (pop && pop_entry.eom) begin
			shreg_q <= pop_entry.rem;
		end
		if (out_free) begin
			unique case (state_q)
				ST_DATA: begin
					code_bit_q <= pop_entry.bit_val;
					is_check_q <= 1'b0;
					last_q     <= 1'b0;
				end
				ST_CHECK: begin
					code_bit_q <= shreg_q[cnt_dec[REM_IDX_W-1:0]];
					is_check_q <= 1'b1;
					last_q     <= (cnt_q == DEG_W'(1));
				end
				default: begin
					code_bit_q <= 1'b0;
					is_check_q <= 1'b0;
					last_q     <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_DATA;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			unique case (state_q)
				ST_DATA: begin
					out_valid_q <= pop;
					if (pop && pop_entry.eom) begin
						cnt_q   <= pop_entry.deg;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					out_valid_q <= 1'b1;
					cnt_q       <= cnt_dec;
					if (cnt_q == DEG_W'(1)) begin
						state_q <= ST_DATA;
					end
				end
				default: begin
					out_valid_q <= 1'b0;
					state_q     <= ST_DATA;
				end
			endcase
		end
	end

endmodule

// ----- design/ccs_checker.sv -----
// Port-level checks for the CRC codeword sender, bound to the top level.
// Depends on crc_codeword_sender_defines.svh.
`timescale 1ns / 1ps
`include "crc_codeword_sender_defines.svh"
module ccs_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic code_bit,
	input logic is_check_bit,
	input logic last_code_bit
);

	// a stalled output word holds
	`CCS_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(code_bit) && $stable(is_check_bit) && $stable(last_code_bit))

	// only a check bit can close a codeword
	`CCS_ASSERT_NOW(a_last_is_check, out_valid && last_code_bit, is_check_bit)

	// check bits run unbroken up to the last one
	`CCS_ASSERT_NEXT(a_check_run, out_valid && !out_stall && is_check_bit && !last_code_bit,
		!out_valid || is_check_bit)

endmodule

bind crc_codeword_sender ccs_checker u_ccs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.code_bit      (code_bit),
	.is_check_bit  (is_check_bit),
	.last_code_bit (last_code_bit)
);
